>>> sv/fit_policy_block_allocator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fit policy block allocator
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fpba_pkg.sv
// ---------------------------------------------------------------------------
// Fit policy block allocator package
// Request kinds, fit modes, register indexes and field widths.
// ---------------------------------------------------------------------------
package fpba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 16;
    localparam int MODE_W  = 2;
    localparam int NBLK_W  = 7;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 7;
    localparam int IN_D_W  = 24;
    localparam int OUT_D_W = 40;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_CLEAR = 2'd2
    } req_type_t;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    localparam logic [CFG_A_W-1:0] REG_FIT_MODE   = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_NUM_BLOCKS = 1'd1;

endpackage

>>> sv/fit_policy_block_allocator.sv
// ---------------------------------------------------------------------------
// Fit policy block allocator
// Fixed-partition allocator with first, best and worst fit selection.
// ---------------------------------------------------------------------------
// Load and clear transactions return nothing. An allocate scans up to L
// blocks, L = num_blocks capped at the addressable blocks (none when L is 0;
// first fit stops at its first hit), then loads the result register. Input
// is not ready again until the result is loaded, and longer while a stalled
// result holds the register. One read port: one block per cycle.
// Reset clears used/written marks, fit_mode, num_blocks; sizes stay undefined.
// ---------------------------------------------------------------------------
`include "fit_policy_block_allocator_defines.svh"

module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fpba_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [fpba_pkg::CFG_D_W-1:0] cfg_data,
    // request stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fpba_pkg::IN_D_W-1:0]  s_tdata,  // [5:0] block_index, [21:6] item_size
    input  logic [fpba_pkg::REQ_W-1:0]   s_tuser,  // [1:0] req_type
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fpba_pkg::OUT_D_W-1:0] m_tdata,  // [5:0] chosen_block, [21:6] chosen_size,
                                                   // [37:22] fragment
    output logic                         m_tuser   // [0] granted
);
    import fpba_pkg::*;

    // Only indices that a 6-bit block_index can reach ever hold a size.
    localparam int SLOT_N = (MAX_BLOCKS < (1 << IDX_W)) ? MAX_BLOCKS : (1 << IDX_W);
    localparam int SLOT_W = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
    localparam int CNT_W  = $clog2(SLOT_N + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Control and datapath registers
    state_t              state_reg,     state_next;
    logic [MODE_W-1:0]   fit_mode_reg,  fit_mode_next;
    logic [NBLK_W-1:0]   num_blocks_reg, num_blocks_next;
    logic [SIZE_W-1:0]   size_reg,      size_next;
    logic [CNT_W-1:0]    lim_reg,       lim_next;
    logic [CNT_W-1:0]    issue_reg,     issue_next;
    logic                eval_vld_reg,  eval_vld_next;
    logic                eval_ok_reg,   eval_ok_next;
    logic [SLOT_W-1:0]   eval_idx_reg,  eval_idx_next;
    logic                found_reg,     found_next;
    logic [SLOT_W-1:0]   best_idx_reg,  best_idx_next;
    logic [SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [SLOT_N-1:0]   written_reg,   written_next;
    logic [SLOT_N-1:0]   used_reg,      used_next;
    logic                out_vld_reg,   out_vld_next;
    logic                out_grant_reg, out_grant_next;
    logic [IDX_W-1:0]    out_blk_reg,   out_blk_next;
    logic [SIZE_W-1:0]   out_size_reg,  out_size_next;
    logic [SIZE_W-1:0]   out_frag_reg,  out_frag_next;

    // Size memory: one write port for loads, one registered read port for scans
    logic [SIZE_W-1:0]   size_mem [SLOT_N];
    logic [SIZE_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [SLOT_W-1:0]   mem_raddr;

    // Input field unpack
    logic [IDX_W-1:0]    in_blk_idx;
    logic [SIZE_W-1:0]   in_size;
    logic                in_fire;
    logic                load_in_range;
    logic [CNT_W-1:0]    lim_calc;

    // Shared compare unit
    logic                hit;
    logic                take;
    logic                first_mode;
    logic                out_free;
    logic                fin_fire;

    assign in_blk_idx    = s_tdata[IDX_W-1:0];
    assign in_size       = s_tdata[IDX_W+SIZE_W-1:IDX_W];
    assign in_fire       = s_tvalid && s_tready;
    assign load_in_range = (32'(in_blk_idx) < SLOT_N);
    assign lim_calc      = (32'(num_blocks_reg) > SLOT_N) ? CNT_W'(SLOT_N)
                                                           : CNT_W'(num_blocks_reg);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = out_grant_reg;
    assign m_tdata   = {2'b00, out_frag_reg, out_size_reg, out_blk_reg};

    assign mem_we    = in_fire && (req_type_t'(s_tuser) == REQ_LOAD) && load_in_range;
    assign mem_waddr = in_blk_idx[SLOT_W-1:0];
    assign mem_raddr = issue_reg[SLOT_W-1:0];

    // Candidate: written, unused, large enough. Take it if it is the first
    // hit or it beats the current pick under the selected policy; ties keep
    // the lower index because only a strict compare replaces the pick.
    assign first_mode = (fit_mode_reg != FIT_BEST) && (fit_mode_reg != FIT_WORST);
    assign hit        = eval_vld_reg && eval_ok_reg && (rd_data_reg >= size_reg);
    assign take       = hit && (!found_reg
                        || ((fit_mode_reg == FIT_BEST)  && (rd_data_reg < best_size_reg))
                        || ((fit_mode_reg == FIT_WORST) && (rd_data_reg > best_size_reg)));

    // Result register is free when empty or being drained this cycle.
    assign out_free = !out_vld_reg || m_tready;
    assign fin_fire = (state_reg == ST_FIN) && out_free;

    always_comb
    begin
        state_next      = state_reg;
        fit_mode_next   = fit_mode_reg;
        num_blocks_next = num_blocks_reg;
        size_next       = size_reg;
        lim_next        = lim_reg;
        issue_next      = issue_reg;
        eval_vld_next   = eval_vld_reg;
        eval_ok_next    = eval_ok_reg;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        written_next    = written_reg;
        used_next       = used_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_grant_next  = out_grant_reg;
        out_blk_next    = out_blk_reg;
        out_size_next   = out_size_reg;
        out_frag_next   = out_frag_reg;

        // Register writes; unknown indexes drop.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIT_MODE:   fit_mode_next   = cfg_data[MODE_W-1:0];
                REG_NUM_BLOCKS: num_blocks_next = cfg_data[NBLK_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type_t'(s_tuser))
                        REQ_LOAD:
                        begin
                            if (load_in_range)
                            begin
                                written_next[in_blk_idx[SLOT_W-1:0]] = 1'b1;
                            end
                        end
                        REQ_ALLOC:
                        begin
                            size_next      = in_size;
                            lim_next       = lim_calc;
                            issue_next     = '0;
                            eval_vld_next  = 1'b0;
                            found_next     = 1'b0;
                            best_idx_next  = '0;
                            best_size_next = '0;
                            state_next     = (lim_calc == '0) ? ST_FIN : ST_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            used_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue stage: read the next block and capture its marks.
                if (issue_reg < lim_reg)
                begin
                    eval_vld_next = 1'b1;
                    eval_ok_next  = written_reg[mem_raddr] && !used_reg[mem_raddr];
                    eval_idx_next = mem_raddr;
                    issue_next    = issue_reg + CNT_W'(1);
                end
                else
                begin
                    eval_vld_next = 1'b0;
                end

                // Compare stage: judge the block read in the previous cycle.
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = eval_idx_reg;
                    best_size_next = rd_data_reg;
                end

                // Stop at the first hit under first fit, else after the last block.
                if ((hit && !found_reg && first_mode) || (issue_reg == lim_reg))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_grant_next = found_reg;
                    if (found_reg)
                    begin
                        out_blk_next            = IDX_W'(best_idx_reg);
                        out_size_next           = best_size_reg;
                        out_frag_next           = best_size_reg - size_reg;
                        used_next[best_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        out_blk_next  = '0;
                        out_size_next = '0;
                        out_frag_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fit_mode_reg   <= '0;
            num_blocks_reg <= '0;
            size_reg       <= '0;
            lim_reg        <= '0;
            issue_reg      <= '0;
            eval_vld_reg   <= 1'b0;
            eval_ok_reg    <= 1'b0;
            eval_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_size_reg  <= '0;
            written_reg    <= '0;
            used_reg       <= '0;
            out_vld_reg    <= 1'b0;
            out_grant_reg  <= 1'b0;
            out_blk_reg    <= '0;
            out_size_reg   <= '0;
            out_frag_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_mode_reg   <= fit_mode_next;
            num_blocks_reg <= num_blocks_next;
            size_reg       <= size_next;
            lim_reg        <= lim_next;
            issue_reg      <= issue_next;
            eval_vld_reg   <= eval_vld_next;
            eval_ok_reg    <= eval_ok_next;
            eval_idx_reg   <= eval_idx_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_size_reg  <= best_size_next;
            written_reg    <= written_next;
            used_reg       <= used_next;
            out_vld_reg    <= out_vld_next;
            out_grant_reg  <= out_grant_next;
            out_blk_reg    <= out_blk_next;
            out_size_reg   <= out_size_next;
            out_frag_reg   <= out_frag_next;
        end
    end

    // Size memory: write on load, registered read at the scan pointer.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_waddr] <= in_size;
        end
        rd_data_reg <= size_mem[mem_raddr];
    end

    // A refusal carries all-zero data.
    `FPBA_ASSERT_NOW(a_refuse_zero, m_tvalid && !m_tuser, m_tdata == '0,
        "refused allocation carries nonzero data")
    // A grant never reports a fragment larger than the block.
    `FPBA_ASSERT_NOW(a_frag_fits, m_tvalid && m_tuser, m_tdata[37:22] <= m_tdata[21:6],
        "fragment exceeds granted block size")
    // The scan pointer never runs past the scan limit.
    `FPBA_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN, issue_reg <= lim_reg,
        "scan pointer past limit")
    // A granted block is marked used right after the result is loaded.
    `FPBA_ASSERT_NEXT(a_mark_used, fin_fire && found_reg, used_reg[$past(best_idx_reg)],
        "granted block not marked used")

endmodule

>>> tb/fit_allocation_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Fit allocation checker
// Watches the register, request and result channels of the allocator, keeps
// its own copy of block sizes, used marks and settings, predicts the grant
// for each allocate transaction and compares every result field by field.
// ---------------------------------------------------------------------------
module fit_allocation_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [fpba_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [fpba_pkg::CFG_D_W-1:0] cfg_data,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [fpba_pkg::IN_D_W-1:0]  s_tdata,   // [5:0] block_index, [21:6] item_size
    input  logic [fpba_pkg::REQ_W-1:0]   s_tuser,   // [1:0] req_type
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [fpba_pkg::OUT_D_W-1:0] m_tdata,   // [5:0] chosen_block, [21:6] chosen_size,
                                                    // [37:22] fragment
    input  logic                         m_tuser,   // [0] granted
    output int                           pending,
    output int                           fail_count,
    output int                           grants,
    output int                           refusals
);
    import fpba_pkg::*;

    localparam int SIZE_LSB   = IDX_W;
    localparam int FRAG_LSB   = IDX_W + SIZE_W;
    localparam int PAD_LSB    = IDX_W + 2 * SIZE_W;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  blk;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] frag;
    } grant_t;

    logic [SIZE_W-1:0] size_of [MAX_BLOCKS_DEF];
    bit                taken   [MAX_BLOCKS_DEF];
    bit                loaded  [MAX_BLOCKS_DEF];
    logic [MODE_W-1:0] mode;
    logic [NBLK_W-1:0] nblocks;
    grant_t            grant_q [$];
    grant_t            seen;
    grant_t            due;

    task automatic report_mismatch(string what, logic [SIZE_W-1:0] got,
                                   logic [SIZE_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Scan the blocks in play and claim the one the fit mode selects.
    function automatic grant_t choose_block(logic [SIZE_W-1:0] want);
        int     limit;
        int     pick;
        grant_t g;
        limit = (nblocks > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(nblocks);
        pick  = -1;
        for (int j = 0; j < limit; j++)
        begin
            if (!loaded[j] || taken[j] || size_of[j] < want)
                continue;
            if (pick < 0)
            begin
                pick = j;
                if (mode != FIT_BEST && mode != FIT_WORST)
                    break;
            end
            else if (mode == FIT_BEST && size_of[j] < size_of[pick])
                pick = j;
            else if (mode == FIT_WORST && size_of[j] > size_of[pick])
                pick = j;
        end
        g = '0;
        if (pick >= 0)
        begin
            taken[pick] = 1'b1;
            g.granted   = 1'b1;
            g.blk       = IDX_W'(pick);
            g.size      = size_of[pick];
            g.frag      = size_of[pick] - want;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_BLOCKS_DEF; j++)
            begin
                taken[j]  = 1'b0;
                loaded[j] = 1'b0;
            end
            mode    = FIT_FIRST;
            nblocks = '0;
            grant_q.delete();
            pending <= 0;
        end
        else
        begin
            // a result can never belong to a request taken at the same edge
            if (m_tvalid && m_tready)
            begin
                seen.granted = m_tuser;
                seen.blk     = m_tdata[IDX_W-1:0];
                seen.size    = m_tdata[SIZE_LSB +: SIZE_W];
                seen.frag    = m_tdata[FRAG_LSB +: SIZE_W];
                if (grant_q.size() == 0)
                    report_mismatch("result with nothing outstanding, chosen_block",
                                    seen.blk, '0);
                else
                begin
                    due = grant_q.pop_front();
                    if (seen.granted !== due.granted)
                        report_mismatch("granted", seen.granted, due.granted);
                    if (seen.blk !== due.blk)
                        report_mismatch("chosen_block", seen.blk, due.blk);
                    if (seen.size !== due.size)
                        report_mismatch("chosen_size", seen.size, due.size);
                    if (seen.frag !== due.frag)
                        report_mismatch("fragment", seen.frag, due.frag);
                    if (due.granted)
                        grants++;
                    else
                        refusals++;
                end
                if (m_tdata[OUT_D_W-1:PAD_LSB] !== '0)
                    report_mismatch("tdata padding", m_tdata[OUT_D_W-1:PAD_LSB], '0);
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIT_MODE)
                    mode = cfg_data[MODE_W-1:0];
                else if (cfg_index == REG_NUM_BLOCKS)
                    nblocks = cfg_data[NBLK_W-1:0];
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    REQ_LOAD:
                    begin
                        size_of[s_tdata[IDX_W-1:0]] = s_tdata[SIZE_LSB +: SIZE_W];
                        loaded[s_tdata[IDX_W-1:0]]  = 1'b1;
                    end
                    REQ_ALLOC:
                        grant_q.push_back(choose_block(s_tdata[SIZE_LSB +: SIZE_W]));
                    REQ_CLEAR:
                        for (int j = 0; j < MAX_BLOCKS_DEF; j++)
                            taken[j] = 1'b0;
                    default:
                        ;
                endcase
            end

            pending <= grant_q.size();
        end
    end

endmodule

>>> tb/fit_policy_block_allocator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Fit policy block allocator testbench
// Drives load, allocate, clear and unused-kind transactions with random
// idling on both streams, sweeps every fit mode and block counts from 0 to
// 127, and leaves prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module fit_policy_block_allocator_test;
    import fpba_pkg::*;

    localparam int HALF_PERIOD     = 4;
    // wait after draining: longer than the longest allocate scan
    localparam int LATENCY_SLACK   = 80;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_BURST      = 32;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int QUIET_PHASE     = 2;
    localparam int PAUSE_PHASE     = 1;
    localparam int HOLD_PHASE      = 5;

    // request kind and fit mode codes the package leaves unnamed
    localparam logic [REQ_W-1:0]  REQ_SPARE = 2'd3;
    localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CFG_A_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic [IN_D_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]   s_tuser   = '0;
    logic               m_tready  = 1'b0;
    logic               cfg_ready;
    logic               s_tready;
    logic               m_tvalid;
    logic [OUT_D_W-1:0] m_tdata;
    logic               m_tuser;

    int pending;
    int fail_count;
    int grants;
    int refusals;

    // stimulus-side state: gap control and the sizes last loaded per block
    bit                quiet;
    bit                hold_req;
    logic [SIZE_W-1:0] loaded_size [MAX_BLOCKS_DEF];
    int                n_load;
    int                n_alloc;
    int                n_clear;
    int                n_spare;

    fit_policy_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fit_allocation_checker audit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .fail_count (fail_count),
        .grants     (grants),
        .refusals   (refusals)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Block sizes: extremes, a small set of round values that forces ties
    // between blocks, and fully random values.
    function automatic logic [SIZE_W-1:0] pick_block_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        if (roll < 45)
            return SIZE_W'(100 * $urandom_range(1, 8));
        return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    endfunction

    // Request sizes: mostly at or just under the size of a block in play, so
    // grants, exact fits and near misses all happen; the rest is noise.
    function automatic logic [SIZE_W-1:0] pick_request(int span);
        int                roll;
        logic [SIZE_W-1:0] base;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 10)
            return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
        if (roll < 16)
            return '0;
        if (roll < 22)
            return '1;
        base = loaded_size[$urandom_range(0, span - 1)];
        if (roll < 35)
            return base;
        if (roll < 40)
            return base + 1'b1;
        if (roll < 70)
            return base - SIZE_W'($urandom_range(0, (base > 64) ? 64 : base));
        return base - SIZE_W'($urandom_range(0, base));
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays
    // high into the next request when no gap follows.
    task automatic send_req(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                            logic [SIZE_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_D_W - IDX_W - SIZE_W){1'b0}}, size, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (kind)
            REQ_LOAD:  n_load++;
            REQ_ALLOC: n_alloc++;
            REQ_CLEAR: n_clear++;
            default:   n_spare++;
        endcase
    endtask

    task automatic load_block(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] size);
        loaded_size[idx] = size;
        send_req(REQ_LOAD, idx, size);
    endtask

    // Drop valid, wait for every outstanding grant, then let a full scan's
    // worth of cycles pass so a trailing load or clear has settled too.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] index, logic [CFG_D_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fit mode lives in the low bits; fill the rest with random junk.
    task automatic set_mode(logic [MODE_W-1:0] m);
        logic [CFG_D_W-1:0] word;
        word = CFG_D_W'($urandom_range(0, (1 << CFG_D_W) - 1));
        word[MODE_W-1:0] = m;
        write_reg(REG_FIT_MODE, word);
    endtask

    task automatic random_item(int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)
            load_block(IDX_W'($urandom_range(0, MAX_BLOCKS_DEF - 1)), pick_block_size());
        else if (roll < 20)
            send_req(REQ_CLEAR, IDX_W'($urandom), SIZE_W'($urandom));
        else if (roll < 22)
            send_req(REQ_SPARE, IDX_W'($urandom), SIZE_W'($urandom));
        else
            send_req(REQ_ALLOC, IDX_W'($urandom), pick_request(span));
    endtask

    // Result side: runs of ready broken by stalls. A hold request from the
    // stimulus starts one long stall at once, counted here.
    initial
    begin : sink
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                run_left   = 0;
                stall_left = HOLD_CYCLES;
            end
            if (run_left == 0 && stall_left == 0)
            begin
                run_left   = $urandom_range(1, 16);
                stall_left = pick_gap();
            end
            if (run_left > 0)
            begin
                m_tready <= 1'b1;
                run_left--;
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #(8_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int               nb;
        int               span;
        logic [MODE_W-1:0] mode_now;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // No block count set yet, so nothing takes part and the request is refused.
        send_req(REQ_ALLOC, '0, 16'd5);
        load_block(6'd0, 16'd100);
        load_block(6'd1, 16'd40);
        load_block(6'd2, 16'hFFFF);
        load_block(6'd3, 16'd40);
        // unused kind: no effect, no result
        send_req(REQ_SPARE, '1, '1);
        drain();
        write_reg(REG_NUM_BLOCKS, 7'd4);
        set_mode(FIT_FIRST);
        // first fit stops at block 0 and leaves a fragment of 60
        send_req(REQ_ALLOC, '1, 16'd40);
        drain();
        set_mode(FIT_BEST);
        // two equal smallest blocks: the lower index wins, then the other one
        send_req(REQ_ALLOC, '0, 16'd40);
        send_req(REQ_ALLOC, '0, 16'd40);
        // zero request still takes the largest remaining block
        send_req(REQ_ALLOC, '0, 16'd0);
        // every block used: refused, all fields zero
        send_req(REQ_ALLOC, '0, 16'd1);
        send_req(REQ_CLEAR, '1, '1);
        drain();
        set_mode(FIT_WORST);
        // largest block, full-scale fragment
        send_req(REQ_ALLOC, '0, 16'd0);
        send_req(REQ_ALLOC, '0, 16'hFFFF);
        // reload a used block: size changes, block stays used
        load_block(6'd2, 16'd70);
        send_req(REQ_ALLOC, '0, 16'd50);
        send_req(REQ_CLEAR, '0, '0);
        drain();
        // spare mode value behaves as first fit
        set_mode(FIT_SPARE);
        send_req(REQ_ALLOC, '0, 16'hFFFF);
        send_req(REQ_ALLOC, '0, 16'd70);

        // ---- load every block so any block count is safe to scan ----
        for (int j = 0; j < MAX_BLOCKS_DEF; j++)
            load_block(IDX_W'(j), pick_block_size());
        send_req(REQ_CLEAR, '0, '0);

        // ---- random phases over fit modes and block counts ----
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:          nb = MAX_BLOCKS_DEF;
                1, 10:      nb = (1 << NBLK_W) - 1;
                3:          nb = 1;
                HOLD_PHASE: nb = 3;
                6:          nb = 0;
                8:          nb = MAX_BLOCKS_DEF - 1;
                default:    nb = $urandom_range(1, (1 << NBLK_W) - 1);
            endcase
            mode_now = MODE_W'(p % 4);
            write_reg(REG_NUM_BLOCKS, NBLK_W'(nb));
            set_mode(mode_now);
            span  = (nb > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : nb;
            quiet = (p == QUIET_PHASE);

            // Stall the result side for a long stretch while requests keep
            // coming, so the block backs up and pushes back on its input.
            if (p == HOLD_PHASE)
            begin
                hold_req = 1'b1;
                repeat (HOLD_BURST)
                    send_req(REQ_ALLOC, '0, pick_request(span));
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // mid-phase: sometimes let everything drain before going on
                if (k == ITEMS_PER_PHASE / 2 && (p == PAUSE_PHASE || $urandom_range(0, 2) == 0))
                    drain();
                random_item(span);
            end
        end
        quiet = 1'b0;
        drain();

        $display("Sent %0d loads, %0d allocations, %0d clears, %0d unused-kind requests",
                 n_load, n_alloc, n_clear, n_spare);
        $display("%0d allocations granted, %0d refused; fit modes 0-3, block counts 0-127",
                 grants, refusals);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/fpba_pkg.sv
sv/fit_policy_block_allocator.sv
tb/fit_allocation_checker.sv
tb/fit_policy_block_allocator_test.sv
